FILE: rtl/ihex_pkg.sv
package ihex_pkg;

	localparam logic [7:0] CHAR_COLON = 8'h3a;
	localparam logic [7:0] CHAR_NL    = 8'h0a;

	localparam logic [2:0] V_OK       = 3'd0;
	localparam logic [2:0] V_END      = 3'd1;
	localparam logic [2:0] V_NO_COLON = 3'd2;
	localparam logic [2:0] V_HDR_HEX  = 3'd3;
	localparam logic [2:0] V_DATA_HEX = 3'd4;
	localparam logic [2:0] V_CK_HEX   = 3'd5;
	localparam logic [2:0] V_MISMATCH = 3'd6;
	localparam logic [2:0] V_BAD_TYPE = 3'd7;

	localparam logic KIND_DATA    = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	localparam int TDATA_W = 48;

	typedef enum logic [2:0] {
		PH_LINE_START = 3'd0,
		PH_HEADER     = 3'd1,
		PH_DATA       = 3'd2,
		PH_CKSUM      = 3'd3,
		PH_SKIP       = 3'd4
	} phase_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] addr;
		logic [7:0]  data;
		logic [2:0]  verdict;
		logic [15:0] line;
	} res_t;

	// bit 4 set: not a hex digit
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b0, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b0, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

FILE: rtl/ihex_parse.sv
module ihex_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         ch,
	output logic               res_valid,
	output ihex_pkg::res_t     res
);
	import ihex_pkg::*;

	phase_t      phase_q, phase_d;
	logic [2:0]  digit_q, digit_d;
	logic [3:0]  hi_q, hi_d;
	logic [7:0]  len_q, len_d;
	logic [15:0] addr_q, addr_d;
	logic        type_end_q, type_end_d;
	logic [7:0]  left_q, left_d;
	logic [7:0]  ofs_q, ofs_d;
	logic [7:0]  sum_q, sum_d;
	logic        halted_q, halted_d;
	logic [15:0] line_q, line_d;

	logic [4:0]  nib;
	logic        nib_bad;
	logic [7:0]  byte_v;
	logic [7:0]  sum_add;
	logic        run;

	assign nib     = hex_nibble(ch);
	assign nib_bad = nib[4];
	assign byte_v  = {hi_q, nib[3:0]};
	assign sum_add = sum_q + byte_v;
	assign run     = step && !halted_q;

	always_comb begin
		phase_d = phase_q;
		if (run) begin
			unique case (phase_q)
				PH_LINE_START: begin
					if (ch == CHAR_COLON) phase_d = PH_HEADER;
				end
				PH_SKIP: begin
					if (ch == CHAR_NL) phase_d = PH_LINE_START;
				end
				PH_HEADER: begin
					if (!nib_bad && digit_q[0] && digit_q[2:1] == 2'd3 && byte_v <= 8'd1)
						phase_d = (len_q != 8'd0) ? PH_DATA : PH_CKSUM;
				end
				PH_DATA: begin
					if (!nib_bad && digit_q[0] && left_q == 8'd1) phase_d = PH_CKSUM;
				end
				PH_CKSUM: begin
					if (!nib_bad && digit_q[0] && sum_add == 8'd0) phase_d = PH_SKIP;
				end
				default: phase_d = PH_LINE_START;
			endcase
		end
	end

	always_comb begin
		digit_d    = digit_q;
		hi_d       = hi_q;
		len_d      = len_q;
		addr_d     = addr_q;
		type_end_d = type_end_q;
		left_d     = left_q;
		ofs_d      = ofs_q;
		sum_d      = sum_q;
		halted_d   = halted_q;
		line_d     = line_q;
		res_valid  = 1'b0;
		res        = '0;
		if (run) begin
			unique case (phase_q)
				PH_LINE_START: begin
					if (line_q != 16'hffff) line_d = line_q + 16'd1;
					digit_d = 3'd0;
					sum_d   = 8'd0;
					if (ch != CHAR_COLON) begin
						halted_d    = 1'b1;
						res_valid   = 1'b1;
						res.kind    = KIND_VERDICT;
						res.verdict = V_NO_COLON;
					end
				end
				PH_SKIP: ;
				PH_HEADER, PH_DATA, PH_CKSUM: begin
					if (nib_bad) begin
						halted_d    = 1'b1;
						res_valid   = 1'b1;
						res.kind    = KIND_VERDICT;
						res.verdict = (phase_q == PH_HEADER) ? V_HDR_HEX :
						              (phase_q == PH_DATA)   ? V_DATA_HEX : V_CK_HEX;
					end else if (!digit_q[0]) begin
						hi_d    = nib[3:0];
						digit_d = digit_q + 3'd1;
					end else begin
						sum_d = sum_add;
						if (phase_q == PH_HEADER) begin
							digit_d = digit_q + 3'd1;
							case (digit_q[2:1])
								2'd0: len_d = byte_v;
								2'd1: addr_d = {byte_v, 8'h00};
								2'd2: addr_d = {addr_q[15:8], byte_v};
								default: begin
									type_end_d = byte_v[0];
									if (byte_v > 8'd1) begin
										halted_d    = 1'b1;
										res_valid   = 1'b1;
										res.kind    = KIND_VERDICT;
										res.verdict = V_BAD_TYPE;
									end else begin
										left_d  = len_q;
										ofs_d   = 8'd0;
										digit_d = 3'd0;
									end
								end
							endcase
						end else if (phase_q == PH_DATA) begin
							digit_d = 3'd0;
							ofs_d   = ofs_q + 8'd1;
							left_d  = left_q - 8'd1;
							if (!type_end_q) begin
								res_valid = 1'b1;
								res.kind  = KIND_DATA;
								res.addr  = addr_q + {8'h00, ofs_q};
								res.data  = byte_v;
							end
						end else begin
							digit_d     = 3'd0;
							res_valid   = 1'b1;
							res.kind    = KIND_VERDICT;
							if (sum_add != 8'd0) begin
								halted_d    = 1'b1;
								res.verdict = V_MISMATCH;
							end else begin
								res.verdict = type_end_q ? V_END : V_OK;
							end
						end
					end
				end
				default: ;
			endcase
		end
		res.line = line_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_LINE_START;
			digit_q    <= '0;
			hi_q       <= '0;
			len_q      <= '0;
			addr_q     <= '0;
			type_end_q <= 1'b0;
			left_q     <= '0;
			ofs_q      <= '0;
			sum_q      <= '0;
			halted_q   <= 1'b0;
			line_q     <= '0;
		end else begin
			phase_q    <= phase_d;
			digit_q    <= digit_d;
			hi_q       <= hi_d;
			len_q      <= len_d;
			addr_q     <= addr_d;
			type_end_q <= type_end_d;
			left_q     <= left_d;
			ofs_q      <= ofs_d;
			sum_q      <= sum_d;
			halted_q   <= halted_d;
			line_q     <= line_d;
		end
	end

endmodule

FILE: rtl/ihex_out_reg.sv
module ihex_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  logic           in_valid,
	input  ihex_pkg::res_t in_res,
	input  logic           out_ready,
	output logic           rdy,
	output logic           out_valid,
	output ihex_pkg::res_t out_res
);
	import ihex_pkg::*;

	logic valid_q;
	res_t res_q;

	assign rdy       = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rdy) begin
			valid_q <= load && in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			res_q <= in_res;
		end
	end

endmodule

FILE: rtl/intel_hex_record_parser_top.sv
// Intel HEX record parser. Takes one ASCII character per transaction on the
// s_axis side and can accept a character every clock cycle unless the output
// register is stalled. Each character passes an input register, is decoded
// against the record state, and any result lands in an output register.
// s_axis_tready drops only while the output register holds an untaken result
// and m_axis_tready is low. Data bytes of type 0 records go out as they
// complete (tuser 0); each checksum is followed by a verdict transaction
// (tuser 1). Bytes of a record are only good once an ok verdict arrives.
// After any error verdict the block consumes input silently until reset.
module intel_hex_record_parser_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,   // [7:0] char_in
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [ihex_pkg::TDATA_W-1:0] m_axis_tdata,   // [15:0] target_address,
	                                                     // [23:16] data_byte,
	                                                     // [26:24] verdict,
	                                                     // [42:27] line_number, [47:43] 0
	output logic                         m_axis_tuser    // [0] item_kind
);
	import ihex_pkg::*;

	logic       vld_s1;
	logic [7:0] ch_s1;
	logic       out_rdy;
	logic       step;
	logic       res_valid;
	res_t       res;
	res_t       res_out;

	assign s_axis_tready = !vld_s1 || out_rdy;
	assign step          = vld_s1 && out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			ch_s1 <= s_axis_tdata;
		end
	end

	ihex_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.ch        (ch_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	ihex_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.in_valid  (res_valid),
		.in_res    (res),
		.out_ready (m_axis_tready),
		.rdy       (out_rdy),
		.out_valid (m_axis_tvalid),
		.out_res   (res_out)
	);

	assign m_axis_tuser = res_out.kind;
	assign m_axis_tdata = {5'b0, res_out.line, res_out.verdict, res_out.data, res_out.addr};

endmodule

FILE: rtl/ihex_checker.sv
module ihex_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic        m_axis_tuser
);
	import ihex_pkg::*;

	logic unused_in;
	assign unused_in = s_axis_tvalid ^ s_axis_tready ^ (^s_axis_tdata);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output changed while stalled");

	a_data_no_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_DATA |-> m_axis_tdata[26:24] == V_OK)
		else $error("data transaction carries a verdict");

	a_verdict_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_VERDICT |-> m_axis_tdata[23:0] == 24'd0)
		else $error("verdict transaction carries address or data");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[47:43] == 5'd0)
		else $error("padding bits set");

	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_VERDICT &&
		m_axis_tdata[26:24] != V_OK && m_axis_tdata[26:24] != V_END |=> !m_axis_tvalid)
		else $error("output after error verdict");

endmodule

bind intel_hex_record_parser_top ihex_checker u_ihex_checker (.*);
